FILE: rtl/grid_mesh_triangulator_macros.svh
// Assertion macros for the grid mesh triangulator checker.
// Depends on nothing; included by the checker file only.
`ifndef GRID_MESH_TRIANGULATOR_MACROS_SVH
`define GRID_MESH_TRIANGULATOR_MACROS_SVH

// same-cycle implication, disabled while rstn is low
`define GMT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while rstn is low
`define GMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gmt_pkg.sv
// Shared constants and types of the grid mesh triangulator.
// Depends on nothing; imported by every RTL module.
package gmt_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 12;
  localparam int COORD_W    = 32;
  localparam int NUM_W      = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [SIZE_W-1:0]         WIDTH_RESET     = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]         HEIGHT_RESET    = SIZE_W'(MAX_HEIGHT);
  localparam logic signed [COORD_W-1:0] THRESHOLD_RESET = -32'sd65536000;

  localparam logic TRI_UPPER = 1'b0;
  localparam logic TRI_LOWER = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0]         image_width;
    logic [SIZE_W-1:0]         image_height;
    logic signed [COORD_W-1:0] valid_threshold;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
  } entry_t;

  typedef struct packed {
    logic             upper_en;
    logic             lower_en;
    logic [NUM_W-1:0] cur;
    logic [NUM_W-1:0] left;
    logic [NUM_W-1:0] up;
    logic [NUM_W-1:0] up_left;
  } job_t;

  typedef struct packed {
    logic [NUM_W-1:0] corner_a;
    logic [NUM_W-1:0] corner_b;
    logic [NUM_W-1:0] corner_c;
    logic             kind;
    logic             last;
  } tri_t;

endpackage

FILE: rtl/gmt_front.sv
// Front end: takes pixels, tests validity, numbers vertices, keeps the line store
// and turns each pixel with enough valid neighbours into a triangle job. Depends on gmt_pkg.
module gmt_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gmt_pkg::cfg_t                        cfg,
  input  logic                                 in_push,
  input  logic signed [gmt_pkg::COORD_W-1:0]   in_x_coord,
  input  logic signed [gmt_pkg::COORD_W-1:0]   in_y_coord,
  input  logic signed [gmt_pkg::COORD_W-1:0]   in_z_coord,
  output logic                                 in_full,
  output logic                                 job_push,
  output gmt_pkg::job_t                        job,
  input  logic                                 job_full
);
  import gmt_pkg::*;

  entry_t mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [NUM_W-1:0] kept_r, kept_nxt;
  entry_t           left_r, left_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  entry_t           s1_cur_r;
  entry_t           s1_left_r;
  logic             s1_emit_r;
  entry_t           up_r;
  entry_t           up_left_r;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic              accept;
  logic              pix_valid;
  logic [NUM_W-1:0]  kept_inc;
  entry_t            cur;
  logic              row_end;
  logic              frame_end;
  logic              has_upper;
  logic              has_lower;
  logic              s1_adv;

  always_comb begin
    priority if (cfg.image_width < SIZE_W'(2)) w_eff = SIZE_W'(2);
    else if (cfg.image_width > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    else w_eff = cfg.image_width;
    priority if (cfg.image_height < SIZE_W'(2)) h_eff = SIZE_W'(2);
    else if (cfg.image_height > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else h_eff = cfg.image_height;
  end

  assign last_col  = COL_W'(w_eff - SIZE_W'(1));
  assign last_row  = ROW_W'(h_eff - SIZE_W'(1));
  assign row_end   = col_r >= last_col;
  assign frame_end = row_end && (row_r >= last_row);

  assign pix_valid = (in_x_coord > cfg.valid_threshold) &&
                     (in_y_coord > cfg.valid_threshold) &&
                     (in_z_coord > cfg.valid_threshold);
  assign kept_inc  = kept_r + NUM_W'(1);
  assign cur.valid = pix_valid;
  assign cur.num   = pix_valid ? kept_inc : '0;

  assign has_upper = s1_emit_r && up_left_r.valid && up_r.valid && s1_left_r.valid;
  assign has_lower = s1_emit_r && s1_cur_r.valid && s1_left_r.valid && up_r.valid;
  assign s1_adv    = s1_valid_r && (!(has_upper || has_lower) || !job_full);
  assign in_full   = s1_valid_r && !s1_adv;
  assign accept    = in_push && !in_full;
  assign job_push  = s1_valid_r && (has_upper || has_lower) && !job_full;

  assign job.upper_en = has_upper;
  assign job.lower_en = has_lower;
  assign job.cur      = s1_cur_r.num;
  assign job.left     = s1_left_r.num;
  assign job.up       = up_r.num;
  assign job.up_left  = up_left_r.num;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    kept_nxt     = kept_r;
    left_nxt     = left_r;
    s1_valid_nxt = s1_adv ? 1'b0 : s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      left_nxt     = cur;
      if (pix_valid) kept_nxt = kept_inc;
      if (row_end) begin
        col_nxt = '0;
        if (frame_end) begin
          row_nxt  = '0;
          kept_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      kept_r     <= '0;
      left_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      kept_r     <= kept_nxt;
      left_r     <= left_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // read-first line store: the entry of this column still holds the row above
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[col_r] <= cur;
      up_r       <= mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r  <= cur;
      s1_left_r <= left_r;
      s1_emit_r <= (col_r != '0) && (row_r != '0);
    end
    if (s1_adv) begin
      up_left_r <= up_r;
    end
  end

endmodule

FILE: rtl/gmt_job_queue.sv
// Short job queue between front end and back end.
// Depends on gmt_pkg.
module gmt_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gmt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output gmt_pkg::job_t head,
  output logic          empty
);
  import gmt_pkg::*;

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/gmt_back.sv
// Back end: expands each job into one or two triangle words and holds the
// output register. Depends on gmt_pkg.
module gmt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gmt_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output gmt_pkg::tri_t out_tri,
  output logic          out_empty,
  input  logic          out_pop
);
  import gmt_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic second_r, second_nxt;
  tri_t tri_r, tri_nxt;
  logic load;
  logic emit_upper;

  assign load       = !out_valid_r || out_pop;
  assign emit_upper = head.upper_en && !second_r;
  assign out_tri    = tri_r;
  assign out_empty  = !out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    second_nxt    = second_r;
    tri_nxt       = tri_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        if (emit_upper) begin
          tri_nxt.corner_a = head.up_left;
          tri_nxt.corner_b = head.up;
          tri_nxt.corner_c = head.left;
          tri_nxt.kind     = TRI_UPPER;
          tri_nxt.last     = !head.lower_en;
          second_nxt       = head.lower_en;
          q_pop            = !head.lower_en;
        end else begin
          tri_nxt.corner_a = head.cur;
          tri_nxt.corner_b = head.left;
          tri_nxt.corner_c = head.up;
          tri_nxt.kind     = TRI_LOWER;
          tri_nxt.last     = 1'b1;
          second_nxt       = 1'b0;
          q_pop            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tri_r <= tri_nxt;
  end

endmodule

FILE: rtl/grid_mesh_triangulator.sv
// Channel  Handshake              Word
// in_      in_push / in_full      in_x_coord, in_y_coord, in_z_coord (Q16.16)
// out_     out_pop / out_empty    out_corner_a/b/c, out_triangle_kind, out_last_of_pixel
// cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel enters per cycle unless in_full is high; each triangle leaves through the single output
// register at one word per cycle while out_pop is high, so a pixel making two triangles gives two words.
// Pixel to first triangle: the stage register takes the pixel, the job queue takes its job,
// then the output register takes the word; a full queue or output can stall between them.
// A four-entry job queue decouples pixel intake from triangle output.
// Reset clears counters, queue and output; the line store is not cleared.
// Top level: configuration registers, front end, job queue, back end.
// Depends on gmt_pkg, gmt_front, gmt_job_queue and gmt_back.
module grid_mesh_triangulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  logic signed [gmt_pkg::COORD_W-1:0]   in_x_coord,
  input  logic signed [gmt_pkg::COORD_W-1:0]   in_y_coord,
  input  logic signed [gmt_pkg::COORD_W-1:0]   in_z_coord,
  output logic                                 in_full,
  output logic [gmt_pkg::NUM_W-1:0]            out_corner_a,
  output logic [gmt_pkg::NUM_W-1:0]            out_corner_b,
  output logic [gmt_pkg::NUM_W-1:0]            out_corner_c,
  output logic                                 out_triangle_kind,
  output logic                                 out_last_of_pixel,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gmt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gmt_pkg::COORD_W-1:0]          cfg_data
);
  import gmt_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t push_job;
  job_t head;
  tri_t out_tri;
  logic job_push;
  logic job_full;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width     = cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height    = cfg_data[SIZE_W-1:0];
        REG_THRESHOLD:    cfg_nxt.valid_threshold = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= WIDTH_RESET;
      cfg_r.image_height    <= HEIGHT_RESET;
      cfg_r.valid_threshold <= THRESHOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .in_z_coord (in_z_coord),
    .in_full    (in_full),
    .job_push   (job_push),
    .job        (push_job),
    .job_full   (job_full)
  );

  gmt_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  gmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_tri   (out_tri),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_corner_a      = out_tri.corner_a;
  assign out_corner_b      = out_tri.corner_b;
  assign out_corner_c      = out_tri.corner_c;
  assign out_triangle_kind = out_tri.kind;
  assign out_last_of_pixel = out_tri.last;

endmodule

FILE: rtl/gmt_checker.sv
// Port-level checker for the grid mesh triangulator and its bind.
// Depends on gmt_pkg and grid_mesh_triangulator_macros.svh.
`include "grid_mesh_triangulator_macros.svh"

module gmt_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic [gmt_pkg::NUM_W-1:0]            out_corner_a,
  input logic [gmt_pkg::NUM_W-1:0]            out_corner_b,
  input logic [gmt_pkg::NUM_W-1:0]            out_corner_c,
  input logic                                 out_triangle_kind,
  input logic                                 out_last_of_pixel,
  input logic                                 out_empty,
  input logic                                 out_pop
);
  import gmt_pkg::*;

  `GMT_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_corner_a) && $stable(out_corner_b) &&
    $stable(out_corner_c) && $stable(out_triangle_kind) && $stable(out_last_of_pixel),
    "result word changed while waiting")

  `GMT_ASSERT_NOW(a_lower_last, clk, rst_n, !out_empty && out_triangle_kind == TRI_LOWER,
    out_last_of_pixel, "lower triangle not marked last of pixel")

  `GMT_ASSERT_NEXT(a_pair_follows, clk, rst_n,
    !out_empty && out_pop && out_triangle_kind == TRI_UPPER && !out_last_of_pixel,
    !out_empty && out_triangle_kind == TRI_LOWER, "second triangle of pixel missing")

  `GMT_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, out_empty,
    "result side not empty after reset")

endmodule

bind grid_mesh_triangulator gmt_checker u_gmt_checker (.*);
